FILE: hdl/binary_to_decimal_ascii_defines.svh
// Assertion macros used by the checker file of the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bda_pkg.sv
// Types, constants and the shift-add-3 step of the decimal text converter.
`default_nettype none

package bda_pkg;

    localparam int VALUE_WIDTH     = 64;
    localparam int ITERS_PER_STAGE = 4;
    localparam int NUM_STAGES      = (VALUE_WIDTH + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    localparam int BIN_W           = NUM_STAGES * ITERS_PER_STAGE;
    localparam int DIGITS          = 20;
    localparam int BCD_W           = DIGITS * 4;
    localparam int DIGIT_IDX_W     = $clog2(DIGITS);
    localparam int IN_W            = 64;
    localparam int CHAR_W          = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [IN_W-1:0]           value_t;
    typedef logic [CHAR_W-1:0]         char_t;
    typedef logic [DIGITS-1:0][3:0]    bcd_t;
    typedef logic [BIN_W-1:0]          bin_t;
    typedef logic [DIGIT_IDX_W-1:0]    digit_idx_t;

    typedef struct packed {
        bcd_t bcd;
        bin_t bin;
    } stage_t;

    // Several double-dabble iterations: adjust every digit of five or more,
    // then shift the binary MSB into the decimal field.
    function automatic stage_t dabble_step(stage_t s);
        stage_t         r;
        logic [BCD_W:0] tmp;
        r = s;
        for (int it = 0; it < ITERS_PER_STAGE; it++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r.bcd[d] >= 4'd5) begin
                    r.bcd[d] = r.bcd[d] + 4'd3;
                end
            end
            tmp   = {r.bcd, r.bin[BIN_W-1]};
            r.bcd = tmp[BCD_W-1:0];
            r.bin = {r.bin[BIN_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bda_in_if.sv
// Input channel carrying one binary value per beat.
`default_nettype none

interface bda_in_if;
    import bda_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/bda_out_if.sv
// Output channel carrying one ASCII digit per beat.
`default_nettype none

interface bda_out_if;
    import bda_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/binary_to_decimal_ascii.sv
// Binary value in, decimal ASCII digits out, most significant digit first,
// without leading zeros; zero gives a single '0'. A value passes a 16-stage
// double-dabble pipeline (four shift-add-3 steps per stage) and then a
// serializer that sends one digit per beat, the final digit marked by last.
// The pipeline takes a value every cycle while the serializer keeps up;
// a value with n decimal digits (1 to 20) holds the serializer until all
// n of its digits have left, so the sustained rate is set by the single
// digit output.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bda_in_if.sink     din,
    bda_out_if.source  dout
);
    import bda_pkg::*;

    stage_t                  stage_reg [NUM_STAGES];
    stage_t                  stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES-1:0]   valid_next;
    logic                    adv;

    logic                    ser_valid_reg;
    logic                    ser_valid_next;
    bcd_t                    ser_bcd_reg;
    bcd_t                    ser_bcd_next;
    digit_idx_t              ser_idx_reg;
    digit_idx_t              ser_idx_next;
    logic                    ser_ready;
    digit_idx_t              lead_idx;
    stage_t                  first_in;

    // The serializer can load when empty or when its final beat leaves now.
    assign ser_ready = !ser_valid_reg || (dout.ready && (ser_idx_reg == '0));
    assign adv       = ser_ready || !valid_reg[NUM_STAGES-1];
    assign din.ready = adv;

    assign first_in.bcd = '0;
    assign first_in.bin = BIN_W'(din.value[VALUE_WIDTH-1:0]);

    always_comb
    begin
        stage_next[0] = dabble_step(first_in);
        valid_next[0] = din.valid;
        for (int s = 1; s < NUM_STAGES; s++) begin
            stage_next[s] = dabble_step(stage_reg[s-1]);
            valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    // Position of the most significant nonzero digit, zero for a zero value.
    always_comb
    begin
        lead_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (stage_reg[NUM_STAGES-1].bcd[d] != 4'd0) begin
                lead_idx = DIGIT_IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_bcd_next   = ser_bcd_reg;
        ser_idx_next   = ser_idx_reg;
        if (ser_ready) begin
            ser_valid_next = valid_reg[NUM_STAGES-1];
            ser_bcd_next   = stage_reg[NUM_STAGES-1].bcd;
            ser_idx_next   = lead_idx;
        end else if (dout.ready) begin
            ser_idx_next = ser_idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_bcd_reg <= ser_bcd_next;
    end

    assign dout.valid     = ser_valid_reg;
    assign dout.character = ASCII_ZERO + {2'b00, ser_bcd_reg[ser_idx_reg]};
    assign dout.last      = (ser_idx_reg == '0);

endmodule

`default_nettype wire

FILE: hdl/bda_checker.sv
// Port-level checks of the decimal text converter and their binding.
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"

module bda_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [5:0] out_character,
    input wire logic       out_last
);
    logic start_reg;

    // High when the next output beat opens a new number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= 1'b1;
        end else if (out_valid && out_ready) begin
            start_reg <= out_last;
        end
    end

    `BDA_ASSERT_NOW(a_digit_range, clk, rst_n, out_valid,
        (out_character >= 6'd48) && (out_character <= 6'd57), "character is not a digit")
    `BDA_ASSERT_NOW(a_no_leading_zero, clk, rst_n,
        out_valid && start_reg && (out_character == 6'd48), out_last, "leading zero emitted")
    `BDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_character) && $stable(out_last), "stalled beat changed")

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .out_character (dout.character),
    .out_last      (dout.last)
);

`default_nettype wire
